// ===== hw/rtl/pspr_pkg.sv =====
// ----------------------------------------------------------------------------
// Progress speed profile package
// Shared widths, register indexes, sequencer states and unit result types.
// ----------------------------------------------------------------------------
package pspr_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned MS_W    = 40;
	localparam int unsigned BYTES_W = 48;
	localparam int unsigned RUN_W   = 7;

	// Serial arithmetic widths: the products stay below 2^58 and divisors below 2^49.
	localparam int unsigned NUM_W = 58;
	localparam int unsigned DEN_W = 49;
	localparam int unsigned K_W   = 10;

	// Milliseconds to seconds scale.
	localparam logic [K_W-1:0] MS_PER_S = 10'd1000;

	// Largest speed that can be shown.
	localparam logic [BYTES_W-1:0] SPEED_MAX = {BYTES_W{1'b1}};

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_TOTAL_BYTES = 1'b0,
		REG_JOB_ELAPSED = 1'b1
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PMUL,
		ST_PDIV,
		ST_TCHK,
		ST_SMUL,
		ST_SDIV,
		ST_APT,
		ST_AMUL,
		ST_ADIV,
		ST_LCHK,
		ST_LMUL,
		ST_LDIV,
		ST_LEMIT,
		ST_MAIN
	} state_t;

	// Result of a serial arithmetic unit.
	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] value;
	} unit_res_t;

endpackage

// ===== hw/rtl/pspr_mul.sv =====
// ----------------------------------------------------------------------------
// Serial constant multiplier
// Shift-and-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pspr_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pspr_pkg::BYTES_W-1:0] mcand,
	input  logic [pspr_pkg::K_W-1:0]     mplier,
	output pspr_pkg::unit_res_t          res
);

	localparam int unsigned CNT_W = $clog2(pspr_pkg::K_W + 1);

	logic [pspr_pkg::NUM_W-1:0] acc_q;
	logic [pspr_pkg::NUM_W-1:0] mc_q;
	logic [pspr_pkg::K_W-1:0]   mp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	// Control: count the multiplier bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pspr_pkg::K_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: add the shifted multiplicand for each set multiplier bit.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= pspr_pkg::NUM_W'(mcand);
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[pspr_pkg::NUM_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[pspr_pkg::K_W-1:1]};
		end
	end

	assign res.done  = done_q;
	assign res.value = acc_q;

endmodule

// ===== hw/rtl/pspr_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pspr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pspr_pkg::NUM_W-1:0] num,
	input  logic [pspr_pkg::DEN_W-1:0] den,
	output pspr_pkg::unit_res_t        res
);

	localparam int unsigned CNT_W = $clog2(pspr_pkg::NUM_W + 1);

	logic [pspr_pkg::DEN_W-1:0] rem_q;
	logic [pspr_pkg::NUM_W-1:0] num_q;
	logic [pspr_pkg::DEN_W-1:0] den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pspr_pkg::DEN_W:0]   shifted;
	logic [pspr_pkg::DEN_W:0]   trial;
	logic                       qbit;

	// One trial subtraction per cycle.
	always_comb begin
		shifted = {rem_q, num_q[pspr_pkg::NUM_W-1]};
		trial   = shifted - {1'b0, den_q};
		qbit    = (shifted >= {1'b0, den_q});
	end

	// Control: count the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pspr_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits from the right.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[pspr_pkg::DEN_W-1:0] : shifted[pspr_pkg::DEN_W-1:0];
			num_q <= {num_q[pspr_pkg::NUM_W-2:0], qbit};
		end
	end

	assign res.done  = done_q;
	assign res.value = num_q;

endmodule

// ===== hw/rtl/progress_speed_profile.sv =====
// ----------------------------------------------------------------------------
// Progress speed profile
// Turns progress readings into runs of (speed, start point, length).
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | reading_ms, reading_bytes, restart
// output  | out       | out_valid / out_stall | run_speed, run_start, run_length,
//         |           |                       | last_of_input
// config  | in        | cfg_we                | cfg_index, cfg_data
//
// An item is taken only while the sequencer is idle. A skipped reading goes
// back to idle without drawing; a reading that draws runs a multiply and a
// divide for its point (not at the total) and for its speed, and more when the
// level run is built. Each unit holds the sequencer, one bit per cycle.
// Reset clears the anchor, the drawn point count and both registers.
// A stalled output holds the sequencer in its emit state until taken.
// ----------------------------------------------------------------------------
module progress_speed_profile #(
	parameter int unsigned POINTS = 100
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pspr_pkg::MS_W-1:0]    reading_ms,
	input  logic [pspr_pkg::BYTES_W-1:0] reading_bytes,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pspr_pkg::BYTES_W-1:0] run_speed,
	output logic [pspr_pkg::RUN_W-1:0]   run_start,
	output logic [pspr_pkg::RUN_W-1:0]   run_length,
	output logic                         last_of_input,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [pspr_pkg::BYTES_W-1:0] cfg_data
);

	localparam int unsigned PT_W = $clog2(POINTS + 1);
	localparam logic [PT_W-1:0] PT_MAX = PT_W'(POINTS);
	localparam logic [pspr_pkg::K_W-1:0] K_PTS = pspr_pkg::K_W'(2 * POINTS);

	pspr_pkg::state_t state_q, state_d;

	logic [pspr_pkg::BYTES_W-1:0] total_q;
	logic [pspr_pkg::MS_W-1:0]    job_q;
	logic [pspr_pkg::MS_W-1:0]    anc_ms_q;
	logic [pspr_pkg::BYTES_W-1:0] anc_b_q;
	logic [PT_W-1:0]              pd_q;
	logic                         anc_valid_q;

	logic [pspr_pkg::MS_W-1:0]    ms_q;
	logic [pspr_pkg::BYTES_W-1:0] bytes_q;
	logic                         rst_q;
	logic [PT_W-1:0]              point_q;
	logic [PT_W-1:0]              lenp_q;
	logic [PT_W-1:0]              len_q;
	logic [pspr_pkg::BYTES_W-1:0] speed_q;
	logic [pspr_pkg::BYTES_W-1:0] level_q;

	logic                         out_valid_q;
	logic [pspr_pkg::BYTES_W-1:0] out_speed_q;
	logic [pspr_pkg::RUN_W-1:0]   out_start_q;
	logic [pspr_pkg::RUN_W-1:0]   out_len_q;
	logic                         out_last_q;

	logic                         mul_start;
	logic [pspr_pkg::BYTES_W-1:0] mul_mc;
	logic [pspr_pkg::K_W-1:0]     mul_k;
	pspr_pkg::unit_res_t          mul_res;
	logic                         div_start;
	logic [pspr_pkg::NUM_W-1:0]   div_num;
	logic [pspr_pkg::DEN_W-1:0]   div_den;
	pspr_pkg::unit_res_t          div_res;

	logic                         in_acc;
	logic                         out_free;
	logic                         out_load;
	logic [PT_W-1:0]              len_min;
	logic [pspr_pkg::BYTES_W-1:0] quo_sat;
	logic [pspr_pkg::NUM_W-1:0]   pt_num;
	logic [pspr_pkg::DEN_W-1:0]   pt_den;

	// Shared arithmetic units.
	pspr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mc),
		.mplier (mul_k),
		.res    (mul_res)
	);

	pspr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// Helpers for the handshakes, point rounding, saturation and the level run length.
	always_comb begin
		in_acc   = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		out_load = out_free && (state_q == pspr_pkg::ST_LEMIT || state_q == pspr_pkg::ST_MAIN);
		len_min  = (lenp_q > point_q) ? point_q : lenp_q;
		quo_sat  = (div_res.value[pspr_pkg::NUM_W-1:pspr_pkg::BYTES_W] != '0)
			? pspr_pkg::SPEED_MAX : div_res.value[pspr_pkg::BYTES_W-1:0];
		pt_num   = mul_res.value + pspr_pkg::NUM_W'(total_q);
		pt_den   = {total_q, 1'b0};
	end

	// Next state and unit starts.
	always_comb begin
		state_d   = state_q;
		in_stall  = (state_q != pspr_pkg::ST_IDLE);
		mul_start = 1'b0;
		mul_mc    = bytes_q;
		mul_k     = K_PTS;
		div_start = 1'b0;
		div_num   = pt_num;
		div_den   = pt_den;
		case (state_q)
			pspr_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = pspr_pkg::ST_CHECK;
				end
			end
			pspr_pkg::ST_CHECK: begin
				if (rst_q || !anc_valid_q || total_q == '0 || bytes_q < anc_b_q) begin
					state_d = pspr_pkg::ST_IDLE;
				end else if (bytes_q >= total_q) begin
					state_d = pspr_pkg::ST_TCHK;
				end else begin
					mul_start = 1'b1;
					state_d   = pspr_pkg::ST_PMUL;
				end
			end
			pspr_pkg::ST_PMUL: begin
				if (mul_res.done) begin
					div_start = 1'b1;
					state_d   = pspr_pkg::ST_PDIV;
				end
			end
			pspr_pkg::ST_PDIV: begin
				if (div_res.done) begin
					state_d = pspr_pkg::ST_TCHK;
				end
			end
			pspr_pkg::ST_TCHK: begin
				if (ms_q <= anc_ms_q || point_q <= pd_q) begin
					state_d = pspr_pkg::ST_IDLE;
				end else begin
					mul_start = 1'b1;
					mul_mc    = bytes_q - anc_b_q;
					mul_k     = pspr_pkg::MS_PER_S;
					state_d   = pspr_pkg::ST_SMUL;
				end
			end
			pspr_pkg::ST_SMUL: begin
				if (mul_res.done) begin
					div_start = 1'b1;
					div_num   = mul_res.value;
					div_den   = pspr_pkg::DEN_W'(ms_q - anc_ms_q);
					state_d   = pspr_pkg::ST_SDIV;
				end
			end
			pspr_pkg::ST_SDIV: begin
				if (div_res.done) begin
					state_d = (pd_q == '0) ? pspr_pkg::ST_APT : pspr_pkg::ST_MAIN;
				end
			end
			pspr_pkg::ST_APT: begin
				if (anc_b_q >= total_q) begin
					state_d = pspr_pkg::ST_LCHK;
				end else begin
					mul_start = 1'b1;
					mul_mc    = anc_b_q;
					state_d   = pspr_pkg::ST_AMUL;
				end
			end
			pspr_pkg::ST_AMUL: begin
				if (mul_res.done) begin
					div_start = 1'b1;
					state_d   = pspr_pkg::ST_ADIV;
				end
			end
			pspr_pkg::ST_ADIV: begin
				if (div_res.done) begin
					state_d = pspr_pkg::ST_LCHK;
				end
			end
			pspr_pkg::ST_LCHK: begin
				if (len_min == '0) begin
					state_d = pspr_pkg::ST_MAIN;
				end else if (job_q == '0) begin
					state_d = pspr_pkg::ST_LEMIT;
				end else begin
					mul_start = 1'b1;
					mul_mc    = anc_b_q;
					mul_k     = pspr_pkg::MS_PER_S;
					state_d   = pspr_pkg::ST_LMUL;
				end
			end
			pspr_pkg::ST_LMUL: begin
				if (mul_res.done) begin
					div_start = 1'b1;
					div_num   = mul_res.value;
					div_den   = pspr_pkg::DEN_W'(job_q);
					state_d   = pspr_pkg::ST_LDIV;
				end
			end
			pspr_pkg::ST_LDIV: begin
				if (div_res.done) begin
					state_d = pspr_pkg::ST_LEMIT;
				end
			end
			pspr_pkg::ST_LEMIT: begin
				if (out_free) begin
					state_d = pspr_pkg::ST_MAIN;
				end
			end
			pspr_pkg::ST_MAIN: begin
				if (out_free) begin
					state_d = pspr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pspr_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pspr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers, anchor state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			job_q       <= '0;
			anc_ms_q    <= '0;
			anc_b_q     <= '0;
			pd_q        <= '0;
			anc_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == pspr_pkg::REG_TOTAL_BYTES) begin
					total_q <= cfg_data;
				end else begin
					job_q <= cfg_data[pspr_pkg::MS_W-1:0];
				end
			end
			// A new run is loaded as the old one leaves.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pspr_pkg::ST_CHECK: begin
					if (rst_q || !anc_valid_q || total_q == '0) begin
						anc_ms_q    <= ms_q;
						anc_b_q     <= bytes_q;
						pd_q        <= '0;
						anc_valid_q <= 1'b1;
					end else if (bytes_q < anc_b_q) begin
						anc_ms_q <= ms_q;
						anc_b_q  <= bytes_q;
					end
				end
				pspr_pkg::ST_LEMIT: begin
					if (out_free) begin
						pd_q <= len_q;
					end
				end
				pspr_pkg::ST_MAIN: begin
					if (out_free) begin
						pd_q     <= point_q;
						anc_ms_q <= ms_q;
						anc_b_q  <= bytes_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item payload, intermediate results and output payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ms_q    <= reading_ms;
			bytes_q <= reading_bytes;
			rst_q   <= restart;
		end
		case (state_q)
			pspr_pkg::ST_CHECK: begin
				point_q <= PT_MAX;
			end
			pspr_pkg::ST_PDIV: begin
				if (div_res.done) begin
					point_q <= div_res.value[PT_W-1:0];
				end
			end
			pspr_pkg::ST_SDIV: begin
				if (div_res.done) begin
					speed_q <= quo_sat;
				end
			end
			pspr_pkg::ST_APT: begin
				lenp_q <= PT_MAX;
			end
			pspr_pkg::ST_ADIV: begin
				if (div_res.done) begin
					lenp_q <= div_res.value[PT_W-1:0];
				end
			end
			pspr_pkg::ST_LCHK: begin
				len_q   <= len_min;
				level_q <= speed_q;
			end
			pspr_pkg::ST_LDIV: begin
				if (div_res.done) begin
					level_q <= quo_sat;
				end
			end
			pspr_pkg::ST_LEMIT: begin
				if (out_free) begin
					out_speed_q <= level_q;
					out_start_q <= '0;
					out_len_q   <= pspr_pkg::RUN_W'(len_q);
					out_last_q  <= 1'b0;
				end
			end
			pspr_pkg::ST_MAIN: begin
				if (out_free) begin
					out_speed_q <= speed_q;
					out_start_q <= pspr_pkg::RUN_W'(pd_q);
					out_len_q   <= pspr_pkg::RUN_W'(point_q - pd_q);
					out_last_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign run_speed     = out_speed_q;
	assign run_start     = out_start_q;
	assign run_length    = out_len_q;
	assign last_of_input = out_last_q;

`ifndef ASSERT_OFF
	// The drawn point count never passes the end of the profile.
	assert property (@(posedge clk) disable iff (!arst_n) pd_q <= PT_MAX)
		else $error("drawn point count beyond profile end");

	// A level run always starts at the first point.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_input |-> run_start == '0)
		else $error("level run not at first point");

	// The two serial units never finish in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_res.done && div_res.done))
		else $error("multiplier and divider finished together");

	// An accepted item is always examined in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == pspr_pkg::ST_CHECK)
		else $error("accepted item not examined");
`endif

endmodule
